FILE: sv/datr_pkg.sv
package datr_pkg;

    localparam int STORE_DEPTH  = 4096;
    localparam int ALPHABET     = 256;
    localparam int AW           = $clog2(STORE_DEPTH);
    localparam int BW           = 14;
    localparam int SW           = AW + 6;
    localparam int SYW          = 8;
    localparam int CLIST_DEPTH  = 256;
    localparam int ROOT_NODE    = 1;
    localparam int ROOT_SPAN    = 256;
    localparam int FIRST_OFFSET = 2;

    typedef logic signed [SW-1:0] wide_t;
    typedef logic [AW-1:0]        addr_t;
    typedef logic signed [BW-1:0] base_t;
    typedef logic [SYW-1:0]       sym_t;

    typedef struct packed {
        logic  we_base;
        logic  we_check;
        addr_t waddr;
        base_t wbase;
        addr_t wcheck;
    } st_wr_t;

    typedef struct packed {
        sym_t  sym;
        base_t cbase;
    } child_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RB,
        ST_RC,
        ST_G_RD,
        ST_G_CMP,
        ST_S_L,
        ST_S_K0,
        ST_S_K1,
        ST_S_K2,
        ST_R0,
        ST_R1,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_Q0,
        ST_Q1,
        ST_Q2,
        ST_Q3,
        ST_Q4,
        ST_DONE
    } state_t;

endpackage

FILE: sv/datr_store.sv
module datr_store (
    input  logic             clk,
    input  datr_pkg::addr_t  raddr,
    input  datr_pkg::st_wr_t wr,
    output datr_pkg::base_t  rbase,
    output datr_pkg::addr_t  rcheck
);
    import datr_pkg::*;

    base_t base_mem [STORE_DEPTH];
    addr_t check_mem [STORE_DEPTH];
    base_t rbase_reg;
    addr_t rcheck_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we_base)
        begin
            base_mem[wr.waddr] <= wr.wbase;
        end
        rbase_reg <= base_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.we_check)
        begin
            check_mem[wr.waddr] <= wr.wcheck;
        end
        rcheck_reg <= check_mem[raddr];
    end

    assign rbase  = rbase_reg;
    assign rcheck = rcheck_reg;

endmodule

FILE: sv/datr_clist.sv
module datr_clist (
    input  logic             clk,
    input  logic             we,
    input  datr_pkg::sym_t   waddr,
    input  datr_pkg::child_t wdata,
    input  datr_pkg::sym_t   raddr,
    output datr_pkg::child_t rdata
);
    import datr_pkg::*;

    child_t mem [CLIST_DEPTH];
    child_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/datr_alu.sv
module datr_alu (
    input  datr_pkg::wide_t x,
    input  datr_pkg::wide_t y,
    input  datr_pkg::wide_t z,
    output datr_pkg::wide_t sum,
    output logic            in_store
);
    import datr_pkg::*;

    // three-operand address add, flag slots that land inside the store
    assign sum      = x + y + z;
    assign in_store = !sum[SW-1] && (sum < wide_t'(STORE_DEPTH));

endmodule

FILE: sv/double_array_trie_engine_unit.sv
// Flow: a lookup byte or a plain insert reads the node's base (ST_RB), then the target slot's
// check (ST_RC), before ST_DONE hands out its result; a target slot outside the store skips
// ST_RC, and a broken-prefix byte goes straight to ST_DONE. An insert that collides scans 256
// slots of the parent, probes offsets one child at a time, then moves children and rewrites
// grandchildren (up to 256 slots per child). Throughput: one item at a time; an item waits in
// ST_DONE while the output register is held. Reset: asynchronous, active low; afterwards all
// 4096 store entries are swept (one entry a cycle) with in_ready low before any item is taken.
module double_array_trie_engine_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [7:0]           symbol,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [11:0]          node,
    output logic                 found,
    output logic                 full_res,
    output logic                 key_end
);
    import datr_pkg::*;

    localparam sym_t ALPHA_LAST = sym_t'(ALPHABET - 1);

    state_t state_reg, state_next;
    addr_t  clr_reg, clr_next;
    addr_t  cur_reg, cur_next;
    logic   missed_reg, missed_next;
    logic   op_reg, op_next;
    sym_t   sym_reg, sym_next;
    logic   last_reg, last_next;
    base_t  ob_reg, ob_next;
    addr_t  nxt_reg, nxt_next;
    sym_t   i_reg, i_next;
    logic [SYW:0] cnt_reg, cnt_next;
    sym_t   maxc_reg, maxc_next;
    addr_t  left_reg, left_next;
    sym_t   k_reg, k_next;
    sym_t   j_reg, j_next;
    wide_t  mv_reg, mv_next;
    wide_t  oc_reg, oc_next;
    wide_t  ol_reg, ol_next;
    addr_t  res_node_reg, res_node_next;
    logic   res_found_reg, res_found_next;
    logic   res_full_reg, res_full_next;
    addr_t  node_reg, node_next;
    logic   found_reg, found_next;
    logic   full_reg, full_next;
    logic   key_end_reg, key_end_next;
    logic   out_valid_reg, out_valid_next;

    // store port
    addr_t  st_raddr;
    st_wr_t st_wr;
    base_t  st_rbase;
    addr_t  st_rcheck;

    // child list port
    logic   cl_we;
    sym_t   cl_waddr;
    child_t cl_wdata;
    sym_t   cl_raddr;
    child_t cl_rdata;

    // shared adder
    wide_t  alu_x, alu_y, alu_z, alu_sum;
    logic   alu_in;

    logic   last_k;

    datr_store u_store (
        .clk    (clk),
        .raddr  (st_raddr),
        .wr     (st_wr),
        .rbase  (st_rbase),
        .rcheck (st_rcheck)
    );

    datr_clist u_clist (
        .clk   (clk),
        .we    (cl_we),
        .waddr (cl_waddr),
        .wdata (cl_wdata),
        .raddr (cl_raddr),
        .rdata (cl_rdata)
    );

    datr_alu u_alu (
        .x        (alu_x),
        .y        (alu_y),
        .z        (alu_z),
        .sum      (alu_sum),
        .in_store (alu_in)
    );

    assign last_k = ({1'b0, k_reg} == (SYW+1)'(cnt_reg - 1'b1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cur_reg       <= addr_t'(ROOT_NODE);
            missed_reg    <= 1'b0;
            op_reg        <= 1'b0;
            sym_reg       <= '0;
            last_reg      <= 1'b0;
            ob_reg        <= '0;
            nxt_reg       <= '0;
            i_reg         <= '0;
            cnt_reg       <= '0;
            maxc_reg      <= '0;
            left_reg      <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            mv_reg        <= '0;
            oc_reg        <= '0;
            ol_reg        <= '0;
            res_node_reg  <= '0;
            res_found_reg <= 1'b0;
            res_full_reg  <= 1'b0;
            node_reg      <= '0;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            key_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            missed_reg    <= missed_next;
            op_reg        <= op_next;
            sym_reg       <= sym_next;
            last_reg      <= last_next;
            ob_reg        <= ob_next;
            nxt_reg       <= nxt_next;
            i_reg         <= i_next;
            cnt_reg       <= cnt_next;
            maxc_reg      <= maxc_next;
            left_reg      <= left_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            mv_reg        <= mv_next;
            oc_reg        <= oc_next;
            ol_reg        <= ol_next;
            res_node_reg  <= res_node_next;
            res_found_reg <= res_found_next;
            res_full_reg  <= res_full_next;
            node_reg      <= node_next;
            found_reg     <= found_next;
            full_reg      <= full_next;
            key_end_reg   <= key_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        missed_next    = missed_reg;
        op_next        = op_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        ob_next        = ob_reg;
        nxt_next       = nxt_reg;
        i_next         = i_reg;
        cnt_next       = cnt_reg;
        maxc_next      = maxc_reg;
        left_next      = left_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        mv_next        = mv_reg;
        oc_next        = oc_reg;
        ol_next        = ol_reg;
        res_node_next  = res_node_reg;
        res_found_next = res_found_reg;
        res_full_next  = res_full_reg;
        node_next      = node_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        key_end_next   = key_end_reg;
        // drop the held result once the consumer takes it
        out_valid_next = out_valid_reg && !out_ready;

        in_ready = 1'b0;
        st_raddr = '0;
        st_wr    = '0;
        cl_we    = 1'b0;
        cl_waddr = '0;
        cl_wdata = '0;
        cl_raddr = '0;
        alu_x    = '0;
        alu_y    = '0;
        alu_z    = '0;

        case (state_reg)
            // sweep the store to its reset contents, root slot gets base 1 and check 1
            ST_CLEAR:
            begin
                st_wr.we_base  = 1'b1;
                st_wr.we_check = 1'b1;
                st_wr.waddr    = clr_reg;
                st_wr.wbase    = (clr_reg == addr_t'(ROOT_NODE)) ? base_t'(1) : '0;
                st_wr.wcheck   = (clr_reg == addr_t'(ROOT_NODE)) ? addr_t'(1) : '0;
                clr_next       = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                st_raddr = cur_reg;
                if (in_valid)
                begin
                    op_next        = op;
                    sym_next       = symbol;
                    last_next      = last;
                    res_node_next  = '0;
                    res_found_next = 1'b0;
                    res_full_next  = 1'b0;
                    // a broken prefix or a symbol outside the alphabet is a plain miss
                    if (missed_reg || ({1'b0, symbol} >= (SYW+1)'(ALPHABET)))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RB;
                    end
                end
            end

            // base of the current node is back: form the target slot
            ST_RB:
            begin
                alu_x    = wide_t'(cur_reg);
                alu_y    = wide_t'(st_rbase);
                alu_z    = wide_t'(sym_reg);
                ob_next  = st_rbase;
                nxt_next = alu_sum[AW-1:0];
                st_raddr = alu_sum[AW-1:0];
                if (alu_in)
                begin
                    state_next = ST_RC;
                end
                else
                begin
                    res_full_next = op_reg;
                    state_next    = ST_DONE;
                end
            end

            ST_RC:
            begin
                if (st_rcheck == cur_reg)
                begin
                    res_node_next  = nxt_reg;
                    res_found_next = 1'b1;
                    state_next     = ST_DONE;
                end
                else if (op_reg)
                begin
                    if (st_rcheck != '0)
                    begin
                        // slot owned by another node: gather and move our children
                        i_next     = '0;
                        cnt_next   = '0;
                        maxc_next  = '0;
                        state_next = ST_G_RD;
                    end
                    else
                    begin
                        st_wr.we_base  = 1'b1;
                        st_wr.we_check = 1'b1;
                        st_wr.waddr    = nxt_reg;
                        st_wr.wcheck   = cur_reg;
                        st_wr.wbase    = (cur_reg == addr_t'(ROOT_NODE)) ?
                                         base_t'(wide_t'(ROOT_SPAN) - wide_t'(nxt_reg)) :
                                         base_t'(1);
                        res_node_next  = nxt_reg;
                        res_found_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            // gather: walk every symbol slot of the parent
            ST_G_RD, ST_G_CMP:
            begin
                alu_x    = wide_t'(cur_reg);
                alu_y    = wide_t'(ob_reg);
                alu_z    = wide_t'(i_reg);
                st_raddr = alu_sum[AW-1:0];
                if ((state_reg == ST_G_RD) && (i_reg != sym_reg) && alu_in)
                begin
                    state_next = ST_G_CMP;
                end
                else
                begin
                    if (i_reg == sym_reg)
                    begin
                        cl_we          = 1'b1;
                        cl_waddr       = cnt_reg[SYW-1:0];
                        cl_wdata.sym   = sym_reg;
                        cl_wdata.cbase = base_t'(1);
                        cnt_next       = cnt_reg + 1'b1;
                        maxc_next      = i_reg;
                    end
                    else if ((state_reg == ST_G_CMP) && (st_rcheck == cur_reg))
                    begin
                        cl_we          = 1'b1;
                        cl_waddr       = cnt_reg[SYW-1:0];
                        cl_wdata.sym   = i_reg;
                        cl_wdata.cbase = st_rbase;
                        cnt_next       = cnt_reg + 1'b1;
                        maxc_next      = i_reg;
                        st_wr.we_base  = 1'b1;
                        st_wr.we_check = 1'b1;
                        st_wr.waddr    = alu_sum[AW-1:0];
                    end
                    if (i_reg == ALPHA_LAST)
                    begin
                        left_next  = addr_t'(FIRST_OFFSET);
                        state_next = ST_S_L;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_G_RD;
                    end
                end
            end

            // search: does the widest child still fit at this offset
            ST_S_L:
            begin
                alu_x  = wide_t'(left_reg);
                alu_y  = wide_t'(maxc_reg);
                k_next = '0;
                if (alu_in)
                begin
                    state_next = ST_S_K0;
                end
                else
                begin
                    state_next = ST_R0;
                end
            end

            ST_S_K0:
            begin
                cl_raddr   = k_reg;
                state_next = ST_S_K1;
            end

            ST_S_K1:
            begin
                alu_x      = wide_t'(left_reg);
                alu_y      = wide_t'(cl_rdata.sym);
                st_raddr   = alu_sum[AW-1:0];
                state_next = ST_S_K2;
            end

            ST_S_K2:
            begin
                if (st_rcheck != '0)
                begin
                    // the last offset of the store clashed too: give up
                    if (left_reg == '1)
                    begin
                        k_next     = '0;
                        state_next = ST_R0;
                    end
                    else
                    begin
                        left_next  = left_reg + 1'b1;
                        state_next = ST_S_L;
                    end
                end
                else if (last_k)
                begin
                    state_next = ST_P0;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_S_K0;
                end
            end

            // no room: put the old children back
            ST_R0:
            begin
                cl_raddr   = k_reg;
                state_next = ST_R1;
            end

            ST_R1:
            begin
                alu_x = wide_t'(cur_reg);
                alu_y = wide_t'(ob_reg);
                alu_z = wide_t'(cl_rdata.sym);
                if (cl_rdata.sym != sym_reg)
                begin
                    st_wr.we_base  = 1'b1;
                    st_wr.we_check = 1'b1;
                    st_wr.waddr    = alu_sum[AW-1:0];
                    st_wr.wbase    = cl_rdata.cbase;
                    st_wr.wcheck   = cur_reg;
                end
                if (last_k)
                begin
                    res_full_next = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_R0;
                end
            end

            // placed: rebase the parent, hold the shift amount
            ST_P0:
            begin
                alu_x         = wide_t'(cur_reg);
                alu_y         = wide_t'(ob_reg);
                alu_z         = -wide_t'(left_reg);
                mv_next       = alu_sum;
                st_wr.we_base = 1'b1;
                st_wr.waddr   = cur_reg;
                st_wr.wbase   = base_t'(wide_t'(left_reg) - wide_t'(cur_reg));
                k_next        = '0;
                state_next    = ST_P1;
            end

            ST_P1:
            begin
                cl_raddr   = k_reg;
                state_next = ST_P2;
            end

            ST_P2:
            begin
                alu_x          = wide_t'(left_reg);
                alu_y          = wide_t'(cl_rdata.sym);
                st_wr.we_base  = 1'b1;
                st_wr.we_check = 1'b1;
                st_wr.waddr    = alu_sum[AW-1:0];
                st_wr.wcheck   = cur_reg;
                st_wr.wbase    = base_t'(wide_t'(cl_rdata.cbase) + mv_reg);
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = ST_Q0;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_P1;
                end
            end

            // grandchildren: repoint checks that still name an old child slot
            ST_Q0:
            begin
                cl_raddr   = k_reg;
                state_next = ST_Q1;
            end

            ST_Q1:
            begin
                alu_x    = wide_t'(cur_reg);
                alu_y    = wide_t'(ob_reg);
                alu_z    = wide_t'(cl_rdata.sym);
                oc_next  = alu_sum;
                ol_next  = alu_sum + wide_t'(cl_rdata.cbase);
                st_raddr = alu_sum[AW-1:0];
                j_next   = '0;
                if (alu_in)
                begin
                    state_next = ST_Q2;
                end
                else
                begin
                    state_next = ST_Q3;
                end
            end

            ST_Q2:
            begin
                if (st_rcheck != '0)
                begin
                    if (last_k)
                    begin
                        res_node_next  = left_reg + addr_t'(sym_reg);
                        res_found_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_Q0;
                    end
                end
                else
                begin
                    state_next = ST_Q3;
                end
            end

            ST_Q3, ST_Q4:
            begin
                alu_x    = ol_reg;
                alu_z    = wide_t'(j_reg);
                st_raddr = alu_sum[AW-1:0];
                if ((state_reg == ST_Q3) && alu_in)
                begin
                    state_next = ST_Q4;
                end
                else
                begin
                    if ((state_reg == ST_Q4) && (wide_t'(st_rcheck) == oc_reg))
                    begin
                        st_wr.we_check = 1'b1;
                        st_wr.waddr    = alu_sum[AW-1:0];
                        st_wr.wcheck   = addr_t'(oc_reg - mv_reg);
                    end
                    if (j_reg != ALPHA_LAST)
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_Q3;
                    end
                    else if (last_k)
                    begin
                        res_node_next  = left_reg + addr_t'(sym_reg);
                        res_found_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_Q0;
                    end
                end
            end

            // hand the item out once the output register is free, advance the walk
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    node_next      = res_node_reg;
                    found_next     = res_found_reg;
                    full_next      = res_full_reg;
                    key_end_next   = last_reg;
                    out_valid_next = 1'b1;
                    if (res_found_reg)
                    begin
                        cur_next = res_node_reg;
                    end
                    else
                    begin
                        missed_next = 1'b1;
                    end
                    if (last_reg)
                    begin
                        cur_next    = addr_t'(ROOT_NODE);
                        missed_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign node      = 12'(node_reg);
    assign found     = found_reg;
    assign full_res  = full_reg;
    assign key_end   = key_end_reg;

endmodule

FILE: tb/tb.sv
module tb;
    import datr_pkg::*;

    // One expected result of the trie engine.
    typedef struct {
        logic [11:0] node;
        logic        found;
        logic        full_res;
        logic        key_end;
    } trie_res_t;

    // Scoreboard: holds its own copy of the double-array trie, walks it
    // for every accepted item and queues the result the engine must give.
    class trie_scoreboard;
        int        bases[STORE_DEPTH];
        int        checks[STORE_DEPTH];
        int        walk_node;
        bit        broken;
        int        kid_sym[256];
        int        kid_base[256];
        int        kid_count;
        trie_res_t pending_q[$];
        int        errors;

        function new();
            foreach (bases[i])
            begin
                bases[i]  = 0;
                checks[i] = 0;
            end
            bases[ROOT_NODE]  = 1;
            checks[ROOT_NODE] = ROOT_NODE;
            walk_node = ROOT_NODE;
            broken    = 0;
            errors    = 0;
        endfunction

        function bit in_range(longint a);
            return a >= 0 && a < STORE_DEPTH;
        endfunction

        function int read_check(longint a);
            return in_range(a) ? checks[a] : 0;
        endfunction

        // Gather the parent's children, move them to the lowest free offset,
        // then fix the checks of the grandchildren. Return -1 when the store is full.
        function longint shift_kids(int p, int c);
            longint ob, lo, mv, a, oc, ol;
            int     maxc;
            bit     placed, clash;
            ob = bases[p];
            maxc = 0;
            kid_count = 0;
            placed = 0;
            for (int i = 0; i < ALPHABET; i++)
            begin
                a = p + ob + i;
                if (i == c)
                begin
                    kid_sym[kid_count]  = c;
                    kid_base[kid_count] = 1;
                    kid_count++;
                    maxc = i;
                end
                else if (in_range(a) && checks[a] == p)
                begin
                    kid_sym[kid_count]  = i;
                    kid_base[kid_count] = bases[a];
                    kid_count++;
                    maxc = i;
                    bases[a]  = 0;
                    checks[a] = 0;
                end
            end
            for (lo = FIRST_OFFSET; lo + maxc < STORE_DEPTH; lo++)
            begin
                clash = 0;
                for (int k = 0; k < kid_count; k++)
                    if (checks[lo + kid_sym[k]] != 0)
                    begin
                        clash = 1;
                        break;
                    end
                if (!clash)
                begin
                    placed = 1;
                    break;
                end
            end
            if (!placed)
            begin
                for (int k = 0; k < kid_count; k++)
                    if (kid_sym[k] != c)
                    begin
                        a = p + ob + kid_sym[k];
                        checks[a] = p;
                        bases[a]  = kid_base[k];
                    end
                return -1;
            end
            mv = p + ob - lo;
            bases[p] = int'(lo - p);
            for (int k = 0; k < kid_count; k++)
            begin
                a = lo + kid_sym[k];
                checks[a] = p;
                bases[a]  = int'(kid_base[k] + mv);
            end
            for (int k = 0; k < kid_count; k++)
            begin
                oc = p + ob + kid_sym[k];
                ol = oc + kid_base[k];
                for (int j = 0; j < ALPHABET; j++)
                begin
                    a = ol + j;
                    if (in_range(a) && checks[a] == oc && read_check(oc) == 0)
                        checks[a] = int'(oc - mv);
                end
            end
            return lo + c;
        endfunction

        function longint add_child(int p, int c);
            longint nxt;
            nxt = p + bases[p] + c;
            if (in_range(nxt) && checks[nxt] != 0)
                return shift_kids(p, c);
            if (!in_range(nxt))
                return -1;
            checks[nxt] = p;
            bases[nxt]  = (p == ROOT_NODE) ? int'(ROOT_SPAN - nxt) : 1;
            return nxt;
        endfunction

        // Advance the walk by one accepted item and queue its result.
        function void note_item(bit is_insert, int sym, bit is_last);
            trie_res_t r;
            longint    nxt, got;
            r.node = 0;
            r.found = 0;
            r.full_res = 0;
            r.key_end = is_last;
            if (!broken && sym < ALPHABET)
            begin
                nxt = walk_node + bases[walk_node] + sym;
                if (in_range(nxt) && checks[nxt] == walk_node)
                begin
                    r.node  = nxt[11:0];
                    r.found = 1;
                end
                else if (is_insert)
                begin
                    got = add_child(walk_node, sym);
                    if (got >= 0)
                    begin
                        r.node  = got[11:0];
                        r.found = 1;
                    end
                    else
                        r.full_res = 1;
                end
            end
            if (r.found)
                walk_node = r.node;
            else
                broken = 1;
            if (is_last)
            begin
                walk_node = ROOT_NODE;
                broken    = 0;
            end
            pending_q.push_back(r);
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void check_result(trie_res_t got);
            trie_res_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected result node=%0d", got.node));
                return;
            end
            want = pending_q.pop_front();
            if (got.node !== want.node)
                report($sformatf("node %0d, want %0d", got.node, want.node));
            if (got.found !== want.found)
                report($sformatf("found %0b, want %0b", got.found, want.found));
            if (got.full_res !== want.full_res)
                report($sformatf("full_res %0b, want %0b", got.full_res, want.full_res));
            if (got.key_end !== want.key_end)
                report($sformatf("key_end %0b, want %0b", got.key_end, want.key_end));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       op;
    logic [7:0] symbol;
    logic       last;
    logic       out_valid;
    logic       out_ready;
    logic [11:0] node;
    logic       found;
    logic       full_res;
    logic       key_end;

    trie_scoreboard trie_sb;

    // Idle odds in percent for each side; long_hold asks the receiver to stall.
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  long_hold;

    double_array_trie_engine_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .symbol    (symbol),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .node      (node),
        .found     (found),
        .full_res  (full_res),
        .key_end   (key_end)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Hard stop: collisions can take a long time, so leave ample room.
    initial
    begin
        #400000000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one item, hold it until taken, then note it in the scoreboard.
    // A random gap may follow, so idle cycles fall on every phase of the engine.
    task automatic send_byte(bit is_insert, logic [7:0] sym, bit is_last);
        op       <= is_insert;
        symbol   <= sym;
        last     <= is_last;
        in_valid <= 1;
        do
            @(posedge clk);
        while (!in_ready);
        trie_sb.note_item(is_insert, sym, is_last);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Send one key; symbols mostly come from a narrow set so paths share
    // prefixes and inserts collide, with a few full-range bytes mixed in.
    task automatic send_key(int key_len, bit is_insert, bit mixed_ops);
        logic [7:0] sym;
        for (int i = 0; i < key_len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                sym = 8'($urandom_range(0, 255));
            else
                sym = 8'($urandom_range(0, 7) * 37);
            send_byte(mixed_ops ? $urandom_range(0, 1) : is_insert, sym,
                      i == key_len - 1);
        end
    endtask

    // Receiver: check every accepted result and pick the next ready level.
    initial
    begin
        int hold_left;
        trie_res_t got;
        hold_left = 0;
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.node     = node;
                got.found    = found;
                got.full_res = full_res;
                got.key_end  = key_end;
                trie_sb.check_result(got);
            end
            if (long_hold && hold_left == 0)
                hold_left = 400;
            if (hold_left > 0)
            begin
                hold_left--;
                if (hold_left == 0)
                    long_hold = 0;
                out_ready <= 0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        trie_sb   = new();
        rst_n     = 0;
        in_valid  = 0;
        op        = 0;
        symbol    = 0;
        last      = 0;
        long_hold = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;

        // Directed: lookup in empty trie, extremes of symbol, a root collision,
        // broken prefix with further bytes, and a key left open across lookups.
        send_byte(0, 8'd0, 1);
        send_byte(1, 8'd0, 1);
        send_byte(1, 8'd255, 1);
        send_byte(1, 8'd255, 0);
        send_byte(1, 8'd0, 0);
        send_byte(1, 8'd170, 1);
        send_byte(1, 8'd85, 0);
        send_byte(1, 8'd1, 1);
        send_byte(0, 8'd255, 0);
        send_byte(0, 8'd0, 0);
        send_byte(0, 8'd170, 1);
        send_byte(0, 8'd9, 0);
        send_byte(0, 8'd255, 0);
        send_byte(1, 8'd3, 1);
        send_byte(1, 8'd1, 0);
        send_byte(1, 8'd2, 0);
        send_byte(1, 8'd3, 1);
        send_byte(1, 8'd2, 0);
        send_byte(1, 8'd2, 1);
        send_byte(0, 8'd1, 0);
        send_byte(0, 8'd2, 0);
        send_byte(0, 8'd3, 1);
        send_byte(0, 8'd128, 1);

        // Random phases; the first also stalls the receiver for a long stretch.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (ph == 0)
                long_hold = 1;
            for (int n = 0; n < 320; )
            begin
                int klen;
                klen = $urandom_range(1, 4);
                send_key(klen, $urandom_range(0, 1), $urandom_range(0, 9) == 0);
                n += klen;
            end
        end

        in_valid <= 0;
        while (trie_sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (trie_sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
